### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on the rising edge and
// disabled while the active-low reset is asserted
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### rtl/stp_pkg.sv
// ----------------------------------------------------------------------------
// stp_pkg
// types and constants of the servo teach and playback unit
// ----------------------------------------------------------------------------
`default_nettype none

package stp_pkg;

  localparam int DEPTH_DEF = 512;

  // command codes of an input word
  typedef enum logic [1:0] {
    CMD_ADC    = 2'd0,
    CMD_RECORD = 2'd1,
    CMD_UART   = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_t;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_CHANNEL_A = 1'b0,
    REG_CHANNEL_B = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DONE
  } state_t;

  // passes of the shared multiplier for one servo
  typedef enum logic [2:0] {
    STEP_SCALE,
    STEP_RECIP,
    STEP_FIX,
    STEP_ANG_SCALE,
    STEP_ANG_RECIP
  } step_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] adc_word;
    logic [7:0]  rx_byte;
  } in_t;

  typedef struct packed {
    logic [11:0] pulse_a;
    logic [11:0] pulse_b;
    logic [7:0]  angle_a;
    logic [7:0]  angle_b;
    logic        auto_mode;
    logic [9:0]  stored_count;
    logic [8:0]  play_index;
  } out_t;

  localparam int          ADC_DONE_BIT = 31;
  localparam logic [11:0] PULSE_MIN    = 12'd500;
  localparam logic [11:0] PULSE_IDLE   = 12'd1000;
  localparam logic [12:0] PULSE_SPAN   = 13'd2000;
  localparam logic [12:0] ADC_FULL     = 13'd4095;
  // floor(n/4095) ~ (n*4097) >> 24, low by at most one
  localparam logic [12:0] RECIP_FULL   = 13'd4097;
  localparam int          RECIP_FULL_SH = 24;
  // 180/2000 reduces to 9/100, and floor(m/100) = (m*5243) >> 19 for m <= 18000
  localparam logic [12:0] ANGLE_NUM    = 13'd9;
  localparam logic [12:0] RECIP_HUND   = 13'd5243;
  localparam int          RECIP_HUND_SH = 19;
  localparam logic [7:0]  BYTE_MANUAL  = 8'h31;
  localparam logic [7:0]  BYTE_AUTO    = 8'h30;
  localparam logic [2:0]  CHAN_A_RST   = 3'd0;
  localparam logic [2:0]  CHAN_B_RST   = 3'd3;

endpackage

`default_nettype wire

### rtl/servo_teach_playback_unit.sv
// ----------------------------------------------------------------------------
// servo_teach_playback_unit
// two-servo teach and playback controller with a shared multiplier datapath
// ----------------------------------------------------------------------------
// A word is taken on a clock edge with start high and busy low. Busy then
// stays high while the result is worked out, and the result is shown on
// out_data for exactly one cycle with out_valid high, in the first cycle that
// busy is low again; the receiver must take it then. The work is done by one
// shared multiplier that makes five passes for each servo (pulse scale,
// reciprocal, correction, angle scale, reciprocal) plus a step to commit the
// state. A new word may be started in the same cycle the result is shown.
// The recorded pairs sit in a DEPTH-entry memory with no clearing pass after
// reset; only recorded entries are ever played. Configuration writes are
// taken at any time but are meant for when the unit is idle.
`default_nettype none

module servo_teach_playback_unit
  import stp_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire in_t        in_data,
  output logic            out_valid,
  output out_t            out_data,
  input  wire logic       cfg_we,
  input  wire reg_idx_t   cfg_idx,
  input  wire logic [2:0] cfg_wdata
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  state_t          state_r, state_nxt;
  step_t           step_r, step_nxt;
  logic            chan_r, chan_nxt;
  cmd_t            cmd_r, cmd_nxt;
  logic [7:0]      byte_r, byte_nxt;
  logic [22:0]     acc_r, acc_nxt;
  logic [10:0]     q_r, q_nxt;
  logic [11:0]     pulse_a_r, pulse_a_nxt, pulse_b_r, pulse_b_nxt;
  logic [7:0]      ang_a_r, ang_a_nxt, ang_b_r, ang_b_nxt;
  logic [11:0]     latest_a_r, latest_a_nxt, latest_b_r, latest_b_nxt;
  logic            mode_r, mode_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [PW-1:0]   ptr_r, ptr_nxt;
  logic [11:0]     drive_a_r, drive_a_nxt, drive_b_r, drive_b_nxt;
  logic [2:0]      ch_a_r, ch_b_r;
  out_t            out_r, out_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic [23:0]     mem [DEPTH];
  logic [23:0]     rd_data_r;
  logic            mem_we;

  logic [22:0]     mul_a;
  logic [12:0]     mul_b;
  logic [35:0]     prod;
  logic [22:0]     rem;
  logic [10:0]     q_fix;
  logic [11:0]     pulse_new;
  logic [CW-1:0]   ptr_inc;
  logic [CW+9:0]   cnt_ext;
  logic [PW+8:0]   ptr_ext;
  logic [11:0]     cur_latest;
  logic [2:0]      adc_ch;

  // shared multiplier operand select
  always_comb begin
    cur_latest = chan_r ? latest_b_r : latest_a_r;
    mul_a = acc_r;
    mul_b = RECIP_FULL;
    unique case (step_r)
      STEP_SCALE: begin
        mul_a = 23'(cur_latest);
        mul_b = PULSE_SPAN;
      end
      STEP_RECIP: begin
        mul_a = acc_r;
        mul_b = RECIP_FULL;
      end
      STEP_FIX: begin
        mul_a = 23'(q_r);
        mul_b = ADC_FULL;
      end
      STEP_ANG_SCALE: begin
        mul_a = 23'(q_r);
        mul_b = ANGLE_NUM;
      end
      STEP_ANG_RECIP: begin
        mul_a = acc_r;
        mul_b = RECIP_HUND;
      end
      default: begin
        mul_a = acc_r;
        mul_b = RECIP_FULL;
      end
    endcase
  end

  assign prod      = {13'd0, mul_a} * {23'd0, mul_b};
  assign rem       = acc_r - prod[22:0];
  assign q_fix     = (rem >= 23'(ADC_FULL)) ? q_r + 11'd1 : q_r;
  assign pulse_new = PULSE_MIN + 12'(q_fix);
  assign ptr_inc   = CW'(ptr_r) + CW'(1);
  assign adc_ch    = in_data.adc_word[26:24];

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    chan_nxt      = chan_r;
    cmd_nxt       = cmd_r;
    byte_nxt      = byte_r;
    acc_nxt       = acc_r;
    q_nxt         = q_r;
    pulse_a_nxt   = pulse_a_r;
    pulse_b_nxt   = pulse_b_r;
    ang_a_nxt     = ang_a_r;
    ang_b_nxt     = ang_b_r;
    latest_a_nxt  = latest_a_r;
    latest_b_nxt  = latest_b_r;
    mode_nxt      = mode_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    drive_a_nxt   = drive_a_r;
    drive_b_nxt   = drive_b_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    mem_we        = 1'b0;
    cnt_ext       = '0;
    ptr_ext       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt   = in_data.cmd;
          byte_nxt  = in_data.rx_byte;
          step_nxt  = STEP_SCALE;
          chan_nxt  = 1'b0;
          state_nxt = ST_CALC;
          if (in_data.cmd == CMD_ADC && in_data.adc_word[ADC_DONE_BIT]) begin
            // channel a wins when both registers match
            if (adc_ch == ch_a_r) begin
              latest_a_nxt = in_data.adc_word[15:4];
            end else if (adc_ch == ch_b_r) begin
              latest_b_nxt = in_data.adc_word[15:4];
            end
          end
        end
      end
      ST_CALC: begin
        unique case (step_r)
          STEP_SCALE: begin
            acc_nxt  = prod[22:0];
            step_nxt = STEP_RECIP;
          end
          STEP_RECIP: begin
            q_nxt    = prod[RECIP_FULL_SH+10:RECIP_FULL_SH];
            step_nxt = STEP_FIX;
          end
          STEP_FIX: begin
            q_nxt = q_fix;
            if (chan_r) begin
              pulse_b_nxt = pulse_new;
            end else begin
              pulse_a_nxt = pulse_new;
            end
            step_nxt = STEP_ANG_SCALE;
          end
          STEP_ANG_SCALE: begin
            acc_nxt  = prod[22:0];
            step_nxt = STEP_ANG_RECIP;
          end
          STEP_ANG_RECIP: begin
            step_nxt = STEP_SCALE;
            if (chan_r) begin
              ang_b_nxt = prod[RECIP_HUND_SH+7:RECIP_HUND_SH];
              state_nxt = ST_DONE;
            end else begin
              ang_a_nxt = prod[RECIP_HUND_SH+7:RECIP_HUND_SH];
              chan_nxt  = 1'b1;
            end
          end
          default: begin
            step_nxt = STEP_SCALE;
          end
        endcase
      end
      ST_DONE: begin
        unique case (cmd_r)
          CMD_ADC: begin
          end
          CMD_RECORD: begin
            if (count_r < CW'(DEPTH)) begin
              mem_we    = 1'b1;
              count_nxt = count_r + CW'(1);
            end
          end
          CMD_UART: begin
            if (byte_r == BYTE_MANUAL) begin
              mode_nxt = 1'b0;
            end else if (byte_r == BYTE_AUTO) begin
              mode_nxt = 1'b1;
              ptr_nxt  = '0;
            end
          end
          CMD_TICK: begin
            if (mode_r) begin
              if (count_r == '0) begin
                drive_a_nxt = PULSE_IDLE;
                drive_b_nxt = PULSE_IDLE;
              end else begin
                drive_a_nxt = rd_data_r[23:12];
                drive_b_nxt = rd_data_r[11:0];
                ptr_nxt     = (ptr_inc >= count_r) ? '0 : ptr_inc[PW-1:0];
              end
            end
          end
          default: begin
          end
        endcase
        // manual mode follows the adc
        if (!mode_nxt) begin
          drive_a_nxt = pulse_a_r;
          drive_b_nxt = pulse_b_r;
        end
        cnt_ext              = {10'd0, count_nxt};
        ptr_ext              = {9'd0, ptr_nxt};
        out_nxt.pulse_a      = drive_a_nxt;
        out_nxt.pulse_b      = drive_b_nxt;
        out_nxt.angle_a      = ang_a_r;
        out_nxt.angle_b      = ang_b_r;
        out_nxt.auto_mode    = mode_nxt;
        out_nxt.stored_count = cnt_ext[9:0];
        out_nxt.play_index   = ptr_ext[8:0];
        out_valid_nxt        = 1'b1;
        state_nxt            = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= STEP_SCALE;
      chan_r      <= 1'b0;
      latest_a_r  <= '0;
      latest_b_r  <= '0;
      mode_r      <= 1'b0;
      count_r     <= '0;
      ptr_r       <= '0;
      drive_a_r   <= PULSE_IDLE;
      drive_b_r   <= PULSE_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      chan_r      <= chan_nxt;
      latest_a_r  <= latest_a_nxt;
      latest_b_r  <= latest_b_nxt;
      mode_r      <= mode_nxt;
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      drive_a_r   <= drive_a_nxt;
      drive_b_r   <= drive_b_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    byte_r    <= byte_nxt;
    acc_r     <= acc_nxt;
    q_r       <= q_nxt;
    pulse_a_r <= pulse_a_nxt;
    pulse_b_r <= pulse_b_nxt;
    ang_a_r   <= ang_a_nxt;
    ang_b_r   <= ang_b_nxt;
    out_r     <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_a_r <= CHAN_A_RST;
      ch_b_r <= CHAN_B_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_CHANNEL_A: ch_a_r <= cfg_wdata;
        REG_CHANNEL_B: ch_b_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // pair store, read continuously at the play pointer
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[PW-1:0]] <= {pulse_a_r, pulse_b_r};
    end
    rd_data_r <= mem[ptr_r];
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`include "assert_macros.svh"

  `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid_r, !out_valid_r)
  `ASSERT_IMPLY(a_count_max, clk, rst_n, 1'b1, count_r <= CW'(DEPTH))
  `ASSERT_IMPLY(a_ptr_in_range, clk, rst_n, count_r != '0, CW'(ptr_r) < count_r)

endmodule

`default_nettype wire

### verif/servo_teach_playback_unit_test.sv
// ----------------------------------------------------------------------------
// servo_teach_playback_unit_test
// self-checking bench for the servo teach and playback unit: a table of
// directed words followed by random traffic, every status word compared
// field by field against its typed table status or a behavioral model of the controller
// ----------------------------------------------------------------------------
module servo_teach_playback_unit_test;
  import stp_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 16;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_t        in_data;
  logic       out_valid;
  out_t       out_data;
  logic       cfg_we;
  reg_idx_t   cfg_idx;
  logic [2:0] cfg_wdata;

  servo_teach_playback_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // model state of the controller
  logic [2:0]  chan_a_m;
  logic [2:0]  chan_b_m;
  logic [11:0] latest_a_m;
  logic [11:0] latest_b_m;
  logic [11:0] drive_a_m;
  logic [11:0] drive_b_m;
  logic        auto_m;
  int unsigned pair_count_m;
  int unsigned play_ptr_m;
  logic [11:0] taught_a [DEPTH_DEF];
  logic [11:0] taught_b [DEPTH_DEF];

  out_t awaited_status [$];
  int   mismatches;
  int   idle_pct;
  int   quiet_cycles;

  typedef struct {
    in_t  word;
    bit   typed;
    out_t status;
  } dir_row_t;

  dir_row_t dir_rows [$];

  function automatic logic [11:0] pulse_of(logic [11:0] v);
    int unsigned t;
    t = v;
    return 12'(500 + (t * 2000) / 4095);
  endfunction

  function automatic logic [7:0] angle_of(logic [11:0] p);
    int unsigned t;
    t = p;
    return 8'(((t - 500) * 180) / 2000);
  endfunction

  function automatic out_t step_servo_model(in_t w);
    out_t        s;
    logic [11:0] val;
    logic [2:0]  ch;
    case (w.cmd)
      CMD_ADC: begin
        if (w.adc_word[ADC_DONE_BIT]) begin
          val = w.adc_word[15:4];
          ch  = w.adc_word[26:24];
          // channel a wins when both registers hold the same number
          if (ch == chan_a_m) latest_a_m = val;
          else if (ch == chan_b_m) latest_b_m = val;
        end
      end
      CMD_RECORD: begin
        if (pair_count_m < DEPTH_DEF) begin
          taught_a[pair_count_m] = pulse_of(latest_a_m);
          taught_b[pair_count_m] = pulse_of(latest_b_m);
          pair_count_m++;
        end
      end
      CMD_UART: begin
        if (w.rx_byte == BYTE_MANUAL) begin
          auto_m = 1'b0;
        end else if (w.rx_byte == BYTE_AUTO) begin
          auto_m     = 1'b1;
          play_ptr_m = 0;
        end
      end
      default: begin
        if (auto_m) begin
          if (pair_count_m == 0) begin
            drive_a_m = PULSE_IDLE;
            drive_b_m = PULSE_IDLE;
          end else begin
            drive_a_m  = taught_a[play_ptr_m];
            drive_b_m  = taught_b[play_ptr_m];
            play_ptr_m = (play_ptr_m + 1 >= pair_count_m) ? 0 : play_ptr_m + 1;
          end
        end
      end
    endcase
    if (!auto_m) begin
      drive_a_m = pulse_of(latest_a_m);
      drive_b_m = pulse_of(latest_b_m);
    end
    s.pulse_a      = drive_a_m;
    s.pulse_b      = drive_b_m;
    s.angle_a      = angle_of(pulse_of(latest_a_m));
    s.angle_b      = angle_of(pulse_of(latest_b_m));
    s.auto_mode    = auto_m;
    s.stored_count = 10'(pair_count_m);
    s.play_index   = 9'(play_ptr_m);
    return s;
  endfunction

  function automatic in_t mk_in(cmd_t c, logic [31:0] wd, logic [7:0] b);
    in_t w;
    w.cmd      = c;
    w.adc_word = wd;
    w.rx_byte  = b;
    return w;
  endfunction

  function automatic out_t mk_st(int pa, int pb, int aa, int ab, bit am, int cnt, int idx);
    out_t s;
    s.pulse_a      = 12'(pa);
    s.pulse_b      = 12'(pb);
    s.angle_a      = 8'(aa);
    s.angle_b      = 8'(ab);
    s.auto_mode    = am;
    s.stored_count = 10'(cnt);
    s.play_index   = 9'(idx);
    return s;
  endfunction

  function automatic void add_row(in_t w, bit typed, out_t s);
    dir_row_t r;
    r.word   = w;
    r.typed  = typed;
    r.status = s;
    dir_rows.push_back(r);
  endfunction

  function automatic string show(out_t s);
    return $sformatf("pa=%0d pb=%0d aa=%0d ab=%0d auto=%0b cnt=%0d idx=%0d",
                     s.pulse_a, s.pulse_b, s.angle_a, s.angle_b, s.auto_mode,
                     s.stored_count, s.play_index);
  endfunction

  // mostly well-formed traffic: done words on the live channels, mode bytes
  function automatic in_t random_word();
    in_t         w;
    int unsigned pick;
    logic [2:0]  ch;
    w.cmd      = CMD_TICK;
    w.adc_word = $urandom;
    w.rx_byte  = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 35) begin
      w.cmd = CMD_ADC;
      if ($urandom_range(9) < 8) begin
        w.adc_word[ADC_DONE_BIT] = 1'b1;
        case ($urandom_range(2))
          0:       ch = chan_a_m;
          1:       ch = chan_b_m;
          default: ch = 3'($urandom);
        endcase
        w.adc_word[26:24] = ch;
      end
      case ($urandom_range(5))
        0:       w.adc_word[15:4] = '0;
        1:       w.adc_word[15:4] = '1;
        default: ;
      endcase
    end else if (pick < 55) begin
      w.cmd = CMD_RECORD;
    end else if (pick < 70) begin
      w.cmd = CMD_UART;
      case ($urandom_range(4))
        0, 1:    w.rx_byte = BYTE_AUTO;
        2, 3:    w.rx_byte = BYTE_MANUAL;
        default: ;
      endcase
    end
    return w;
  endfunction

  // start stays high after acceptance so back-to-back words need no toggle
  task automatic send_word(in_t w, bit typed, out_t typed_st);
    out_t s;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    in_data <= w;
    start   <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    s = step_servo_model(w);
    awaited_status.push_back(typed ? typed_st : s);
  endtask

  task automatic drain(int extra);
    @(negedge clk);
    start <= 1'b0;
    while (awaited_status.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_channels(logic [2:0] a, logic [2:0] b);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_CHANNEL_A;
    cfg_wdata <= a;
    @(negedge clk);
    cfg_idx   <= REG_CHANNEL_B;
    cfg_wdata <= b;
    @(negedge clk);
    cfg_we    <= 1'b0;
    chan_a_m = a;
    chan_b_m = b;
  endtask

  task automatic random_phase(int count);
    repeat (count) send_word(random_word(), 1'b0, '0);
  endtask

  // status check
  always @(posedge clk) begin : check_blk
    out_t exp_st;
    if (rst_n && out_valid === 1'b1) begin
      if (awaited_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %s", show(out_data));
      end else begin
        exp_st = awaited_status.pop_front();
        if (out_data.pulse_a !== exp_st.pulse_a || out_data.pulse_b !== exp_st.pulse_b ||
            out_data.angle_a !== exp_st.angle_a || out_data.angle_b !== exp_st.angle_b ||
            out_data.auto_mode !== exp_st.auto_mode ||
            out_data.stored_count !== exp_st.stored_count ||
            out_data.play_index !== exp_st.play_index) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %s, got %s", show(exp_st), show(out_data));
        end
      end
    end
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("servo_teach_playback_unit_test failed");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_idx      = REG_CHANNEL_A;
    cfg_wdata    = '0;
    mismatches   = 0;
    quiet_cycles = 0;
    idle_pct     = 22;
    chan_a_m     = CHAN_A_RST;
    chan_b_m     = CHAN_B_RST;
    latest_a_m   = '0;
    latest_b_m   = '0;
    drive_a_m    = PULSE_IDLE;
    drive_b_m    = PULSE_IDLE;
    auto_m       = 1'b0;
    pair_count_m = 0;
    play_ptr_m   = 0;

    //      word                                            typed  status
    add_row(mk_in(CMD_TICK,   32'h0,         8'h00),       1'b1, mk_st(500, 500, 0, 0, 0, 0, 0));
    add_row(mk_in(CMD_UART,   32'h0,         BYTE_AUTO),   1'b1, mk_st(500, 500, 0, 0, 1, 0, 0));
    add_row(mk_in(CMD_TICK,   32'hFFFF_FFFF, 8'hFF),       1'b1, mk_st(1000, 1000, 0, 0, 1, 0, 0));
    add_row(mk_in(CMD_UART,   32'h0,         BYTE_MANUAL), 1'b1, mk_st(500, 500, 0, 0, 0, 0, 0));
    add_row(mk_in(CMD_ADC,    32'h8000_FFF0, 8'h00),       1'b1, mk_st(2500, 500, 180, 0, 0, 0, 0));
    add_row(mk_in(CMD_ADC,    32'h8300_FFF0, 8'h00),       1'b1, mk_st(2500, 2500, 180, 180, 0, 0, 0));
    add_row(mk_in(CMD_ADC,    32'h0000_0000, 8'h00),       1'b1, mk_st(2500, 2500, 180, 180, 0, 0, 0));
    add_row(mk_in(CMD_ADC,    32'h7FFF_FFFF, 8'hFF),       1'b1, mk_st(2500, 2500, 180, 180, 0, 0, 0));
    add_row(mk_in(CMD_ADC,    32'h8500_0000, 8'h00),       1'b1, mk_st(2500, 2500, 180, 180, 0, 0, 0));
    add_row(mk_in(CMD_ADC,    32'hFBFF_000F, 8'h00),       1'b1, mk_st(2500, 500, 180, 0, 0, 0, 0));
    add_row(mk_in(CMD_RECORD, 32'h0,         8'h00),       1'b1, mk_st(2500, 500, 180, 0, 0, 1, 0));
    add_row(mk_in(CMD_ADC,    32'h8000_8000, 8'h00),       1'b1, mk_st(1500, 500, 90, 0, 0, 1, 0));
    add_row(mk_in(CMD_RECORD, 32'hFFFF_FFFF, 8'hFF),       1'b1, mk_st(1500, 500, 90, 0, 0, 2, 0));
    add_row(mk_in(CMD_UART,   32'h0,         BYTE_AUTO),   1'b1, mk_st(1500, 500, 90, 0, 1, 2, 0));
    add_row(mk_in(CMD_TICK,   32'h0,         8'h00),       1'b1, mk_st(2500, 500, 90, 0, 1, 2, 1));
    add_row(mk_in(CMD_TICK,   32'h0,         8'h00),       1'b1, mk_st(1500, 500, 90, 0, 1, 2, 0));
    add_row(mk_in(CMD_ADC,    32'h8300_1230, 8'h00),       1'b0, '0);
    add_row(mk_in(CMD_RECORD, 32'h0,         8'h00),       1'b0, '0);
    add_row(mk_in(CMD_TICK,   32'h0,         8'h00),       1'b0, '0);
    add_row(mk_in(CMD_UART,   32'h0,         8'hFF),       1'b0, '0);
    add_row(mk_in(CMD_UART,   32'h0,         8'h00),       1'b0, '0);
    add_row(mk_in(CMD_UART,   32'h0,         BYTE_AUTO),   1'b0, '0);
    add_row(mk_in(CMD_TICK,   32'h0,         8'h00),       1'b0, '0);
    add_row(mk_in(CMD_UART,   32'h0,         BYTE_MANUAL), 1'b0, '0);
    add_row(mk_in(CMD_TICK,   32'h0,         8'h00),       1'b0, '0);
    add_row(mk_in(CMD_ADC,    32'h8000_0010, 8'h00),       1'b0, '0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_channels(CHAN_A_RST, CHAN_B_RST);
    foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].status);
    random_phase(30);

    drain(SETTLE_CYCLES);
    set_channels(3'd7, 3'd0);
    idle_pct = 72;
    random_phase(30);

    // equal channel numbers
    drain(SETTLE_CYCLES);
    set_channels(3'd5, 3'd5);
    idle_pct = 0;
    random_phase(15);

    drain(SETTLE_CYCLES);
    set_channels(3'd0, 3'd7);
    random_phase(15);

    // fill the store, then push past full and play back from a full store
    drain(SETTLE_CYCLES);
    set_channels(3'd2, 3'd6);
    while (pair_count_m < DEPTH_DEF) begin
      send_word(mk_in(CMD_RECORD, $urandom, 8'($urandom)), 1'b0, '0);
    end
    repeat (3) send_word(mk_in(CMD_RECORD, $urandom, 8'($urandom)), 1'b0, '0);
    send_word(mk_in(CMD_UART, $urandom, BYTE_AUTO), 1'b0, '0);
    random_phase(20);

    drain(20);
    if (mismatches == 0 && awaited_status.size() == 0) begin
      $display("servo_teach_playback_unit_test passed");
    end else begin
      $display("servo_teach_playback_unit_test failed");
    end
    $finish;
  end

endmodule
